// File: rtl/otb_pkg.sv
`default_nettype none
package otb_pkg;
    localparam int BINS       = 256;
    localparam int BIN_BITS   = 8;
    localparam int COUNT_BITS = 20;
    localparam int SUM_BITS   = 28;
    localparam int PROD_BITS  = COUNT_BITS + SUM_BITS;   // N*S1, w1*S
    localparam int DIFF_BITS  = PROD_BITS + 1;           // signed difference
    localparam int NUM_BITS   = 2 * PROD_BITS;           // squared difference
    localparam int DEN_BITS   = 2 * COUNT_BITS;          // w1*(N-w1)
    localparam int CMP_BITS   = NUM_BITS + DEN_BITS;     // cross products
    localparam int MUL_BITS   = 32;                      // shared multiplier width
    localparam int PROD_OUT   = 2 * MUL_BITS;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_BIN   = 1'b1;
    localparam logic KIND_THR = 1'b0;
    localparam logic KIND_PIX = 1'b1;
endpackage
`default_nettype wire

// File: rtl/otsu_threshold_binarizer.sv
`default_nettype none
// Binarize: result strobed the cycle after start.
// Accumulate (not last): read the bin, add one, write the bin back.
// Accumulate with frame_last: the bin is written back, then a search over all
//   256 bins through a shared 32x32 multiplier (multiply steps only for bins
//   with both classes filled), then a histogram clear; report strobed at end.
// Reset (rst_n low, asynchronous) clears control, totals and threshold, then
//   a clearing pass over all 256 histogram RAM bins runs with busy high.
module otsu_threshold_binarizer
    import otb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       opcode,
    input  wire logic [7:0] pixel,
    input  wire logic       frame_last,
    output logic            strobe,
    output logic            result_kind,
    output logic [7:0]      threshold,
    output logic [7:0]      binary_pixel,
    output logic            split_found
);
    // Sequencer states, one-hot.
    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,  // sweep histogram to zero
        S_IDLE  = 11'b00000000010,
        S_ARD   = 11'b00000000100,  // bin read in flight
        S_AWR   = 11'b00000001000,  // bin write back
        S_SRD   = 11'b00000010000,  // search: bin read in flight
        S_SACC  = 11'b00000100000,  // search: add bin into w1, s1
        S_SMUL  = 11'b00001000000,  // search: multiply steps
        S_SCMP  = 11'b00010000000,  // search: compare, decide
        S_SNEXT = 11'b00100000000,
        S_DONE  = 11'b01000000000,
        S_RPT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [BIN_BITS-1:0]   addr_reg;          // bin index for clear / search
    logic [BIN_BITS-1:0]   acc_bin_reg;
    logic                  last_reg;
    logic [COUNT_BITS-1:0] n_reg;
    logic [SUM_BITS-1:0]   s_reg;
    logic [COUNT_BITS-1:0] w1_reg;
    logic [SUM_BITS-1:0]   s1_reg;
    logic [7:0]            thr_reg;
    logic [BIN_BITS-1:0]   best_reg;
    logic                  found_reg;
    logic [NUM_BITS-1:0]   best_num_reg;
    logic [DEN_BITS-1:0]   best_den_reg;

    // Working registers of the multiply sequence.
    logic [DIFF_BITS-1:0]  a_reg;    // w1*S, then |difference|
    logic [PROD_BITS-1:0]  b_reg;    // N*S1
    logic [NUM_BITS-1:0]   num_reg;
    logic [DEN_BITS-1:0]   den_reg;
    logic [CMP_BITS-1:0]   lhs_reg;
    logic [CMP_BITS-1:0]   rhs_reg;
    logic [5:0]            step_reg;

    // Histogram RAM.
    logic                  ram_we;
    logic [BIN_BITS-1:0]   ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

    otb_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared 32x32 multiplier; wide products are built from 32-bit limbs.
    logic [MUL_BITS-1:0] mul_a, mul_b;
    logic [PROD_OUT-1:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // Multiply schedule. Each product is a sum of limb products, shifted.
    // Operands are split into 32-bit limbs; step selects limb pair and target.
    // Step 0      : w1*S   (1x1 limbs of 20 and 28 bits, one step); the rest follow below.
    localparam int NL_NUM = (NUM_BITS + MUL_BITS - 1) / MUL_BITS;  // 3
    localparam int NL_DEN = (DEN_BITS + MUL_BITS - 1) / MUL_BITS;  // 2
    localparam int NL_DIF = (PROD_BITS + MUL_BITS - 1) / MUL_BITS; // 2

    // Step map:
    //  0       : a = w1*S
    //  1       : b = N*S1
    //  2       : a = |a-b|   (no multiply)
    //  3..6    : num = a*a   (2x2 limbs)
    //  7       : den = w1*(N-w1)
    //  8..13   : lhs = num*best_den (3x2 limbs)
    //  14..19  : rhs = best_num*den (3x2 limbs)
    localparam logic [5:0] ST_LAST = 6'd19;

    logic [1:0] li, lj;          // limb indices of current step
    logic [7:0] lshift;          // shift in 32-bit units times 32 (limb sum)
    logic [CMP_BITS+PROD_OUT-1:0] term;

    function automatic logic [MUL_BITS-1:0] limb_of(input logic [CMP_BITS-1:0] v,
                                                    input logic [1:0] k);
        logic [CMP_BITS+3*MUL_BITS-1:0] ext;
        ext = {{(3*MUL_BITS){1'b0}}, v};
        return ext[k*MUL_BITS +: MUL_BITS];
    endfunction

    logic [PROD_BITS-1:0] diff_mag;
    always_comb
    begin
        if ({1'b0, a_reg[PROD_BITS-1:0]} >= {1'b0, b_reg})
        begin
            diff_mag = a_reg[PROD_BITS-1:0] - b_reg;
        end
        else
        begin
            diff_mag = b_reg - a_reg[PROD_BITS-1:0];
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        li    = '0;
        lj    = '0;
        if (step_reg == 6'd0)
        begin
            mul_a = MUL_BITS'(w1_reg);
            mul_b = MUL_BITS'(s_reg);
        end
        else if (step_reg == 6'd1)
        begin
            mul_a = MUL_BITS'(n_reg);
            mul_b = MUL_BITS'(s1_reg);
        end
        else if (step_reg >= 6'd3 && step_reg <= 6'd6)
        begin
            li    = 2'((step_reg - 6'd3) >> 1);
            lj    = 2'((step_reg - 6'd3) & 6'd1);
            mul_a = limb_of(CMP_BITS'(a_reg), li);
            mul_b = limb_of(CMP_BITS'(a_reg), lj);
        end
        else if (step_reg == 6'd7)
        begin
            mul_a = MUL_BITS'(w1_reg);
            mul_b = MUL_BITS'(n_reg - w1_reg);
        end
        else if (step_reg >= 6'd8 && step_reg <= 6'd13)
        begin
            li    = 2'((step_reg - 6'd8) >> 1);
            lj    = 2'((step_reg - 6'd8) & 6'd1);
            mul_a = limb_of(CMP_BITS'(num_reg), li);
            mul_b = limb_of(CMP_BITS'(best_den_reg), lj);
        end
        else if (step_reg >= 6'd14 && step_reg <= 6'd19)
        begin
            li    = 2'((step_reg - 6'd14) >> 1);
            lj    = 2'((step_reg - 6'd14) & 6'd1);
            mul_a = limb_of(CMP_BITS'(best_num_reg), li);
            mul_b = limb_of(CMP_BITS'(den_reg), lj);
        end
        lshift = 8'(({6'd0, li} + {6'd0, lj}) * MUL_BITS);
        term   = (CMP_BITS+PROD_OUT)'(mul_p) << lshift;
    end

    logic win;
    always_comb
    begin
        if (!found_reg)
        begin
            win = (num_reg != '0);
        end
        else
        begin
            win = (lhs_reg > rhs_reg);
        end
    end

    logic valid_split;
    assign valid_split = (w1_reg != '0) && (w1_reg < n_reg);

    logic sat;
    assign sat = (n_reg == {COUNT_BITS{1'b1}});

    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_waddr  = addr_reg;
        ram_wdata  = '0;
        ram_raddr  = addr_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (addr_reg == BIN_BITS'(BINS - 1))
                begin
                    state_next = last_reg ? S_RPT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                ram_raddr = pixel;
                if (accept && opcode == OP_ACCUM)
                begin
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                ram_raddr  = acc_bin_reg;
                state_next = S_AWR;
            end
            S_AWR:
            begin
                ram_waddr = acc_bin_reg;
                ram_wdata = ram_rdata + COUNT_BITS'(1);
                ram_we    = !sat;
                state_next = last_reg ? S_SRD : S_IDLE;
            end
            S_SRD:
            begin
                state_next = S_SACC;
            end
            S_SACC:
            begin
                state_next = S_SMUL;
            end
            S_SMUL:
            begin
                if (!valid_split)
                begin
                    state_next = S_SNEXT;
                end
                else if (step_reg == ST_LAST)
                begin
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                state_next = S_SNEXT;
            end
            S_SNEXT:
            begin
                state_next = (addr_reg == BIN_BITS'(BINS - 1)) ? S_DONE : S_SRD;
            end
            S_DONE:
            begin
                state_next = S_CLEAR;
            end
            S_RPT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            addr_reg     <= '0;
            last_reg     <= 1'b0;
            n_reg        <= '0;
            s_reg        <= '0;
            thr_reg      <= '0;
            strobe       <= 1'b0;
            result_kind  <= KIND_THR;
            threshold    <= '0;
            binary_pixel <= '0;
            split_found  <= 1'b0;
            step_reg     <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            strobe    <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + BIN_BITS'(1);
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (opcode == OP_BIN)
                        begin
                            strobe       <= 1'b1;
                            result_kind  <= KIND_PIX;
                            threshold    <= thr_reg;
                            binary_pixel <= (pixel > thr_reg) ? 8'hFF : 8'h00;
                            split_found  <= 1'b0;
                        end
                        else
                        begin
                            acc_bin_reg <= pixel;
                            last_reg    <= frame_last;
                        end
                    end
                end
                S_AWR:
                begin
                    if (!sat)
                    begin
                        n_reg <= n_reg + COUNT_BITS'(1);
                        s_reg <= s_reg + SUM_BITS'(acc_bin_reg);
                    end
                    addr_reg  <= '0;
                    w1_reg    <= '0;
                    s1_reg    <= '0;
                    found_reg <= 1'b0;
                    best_reg  <= '0;
                    best_num_reg <= '0;
                    best_den_reg <= DEN_BITS'(1);
                end
                S_SACC:
                begin
                    w1_reg   <= w1_reg + ram_rdata;
                    s1_reg   <= s1_reg + SUM_BITS'(ram_rdata) * SUM_BITS'(addr_reg);
                    step_reg <= '0;
                    num_reg  <= '0;
                    lhs_reg  <= '0;
                    rhs_reg  <= '0;
                end
                S_SMUL:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd0)
                    begin
                        a_reg <= DIFF_BITS'(mul_p);
                    end
                    else if (step_reg == 6'd1)
                    begin
                        b_reg <= PROD_BITS'(mul_p);
                    end
                    else if (step_reg == 6'd2)
                    begin
                        a_reg <= DIFF_BITS'(diff_mag);
                    end
                    else if (step_reg <= 6'd6)
                    begin
                        num_reg <= num_reg + NUM_BITS'(term);
                    end
                    else if (step_reg == 6'd7)
                    begin
                        den_reg <= DEN_BITS'(mul_p);
                    end
                    else if (step_reg <= 6'd13)
                    begin
                        lhs_reg <= lhs_reg + CMP_BITS'(term);
                    end
                    else
                    begin
                        rhs_reg <= rhs_reg + CMP_BITS'(term);
                    end
                end
                S_SCMP:
                begin
                    if (win)
                    begin
                        found_reg    <= 1'b1;
                        best_reg     <= addr_reg;
                        best_num_reg <= num_reg;
                        best_den_reg <= den_reg;
                    end
                end
                S_SNEXT:
                begin
                    addr_reg <= addr_reg + BIN_BITS'(1);
                end
                S_DONE:
                begin
                    thr_reg  <= 8'(best_reg);
                    n_reg    <= '0;
                    s_reg    <= '0;
                    addr_reg <= '0;
                end
                S_RPT:
                begin
                    last_reg     <= 1'b0;
                    strobe       <= 1'b1;
                    result_kind  <= KIND_THR;
                    threshold    <= thr_reg;
                    binary_pixel <= '0;
                    split_found  <= found_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = &{1'b0, NL_NUM[0], NL_DEN[0], NL_DIF[0], a_reg[DIFF_BITS-1]};
endmodule
`default_nettype wire

// File: rtl/otb_ram.sv
`default_nettype none
module otb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/otb_checker.sv
`default_nettype none
module otb_checker
    import otb_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       opcode,
    input wire logic       strobe,
    input wire logic       result_kind,
    input wire logic [7:0] binary_pixel,
    input wire logic       split_found
);
    // A binarize beat is answered in the next cycle.
    a_bin_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_BIN) |=> (strobe && result_kind == KIND_PIX))
        else $error("binarize beat not answered");

    // Binarized output is either black or white.
    a_bin_val: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result_kind == KIND_PIX) |-> (binary_pixel == 8'h00 || binary_pixel == 8'hFF))
        else $error("binary pixel not 0 or 255");

    // Threshold report carries zero pixel and pixel beat carries no split flag.
    a_rpt_fields: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((result_kind == KIND_THR && binary_pixel == 8'h00)
                    || (result_kind == KIND_PIX && !split_found)))
        else $error("unused result fields not zero");

    // A threshold report never follows directly on an idle cycle with no work.
    a_rpt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result_kind == KIND_THR) |-> $past(busy))
        else $error("report without search");
endmodule

bind otsu_threshold_binarizer otb_checker u_otb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .strobe       (strobe),
    .result_kind  (result_kind),
    .binary_pixel (binary_pixel),
    .split_found  (split_found)
);
`default_nettype wire
